// ----- rtl/core/ctt_pkg.sv -----
`default_nettype none

package ctt_pkg;

   // table geometry
   localparam int ENTRIES      = 16;
   localparam int COORD_BITS   = 12;
   localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_W      = $clog2(ENTRIES + 1);

   // register and field widths
   localparam int RADIUS_W     = 12;
   localparam int ABSENT_CFG_W = 8;
   localparam int ABSENT_W     = 9;
   localparam int SLOT_W       = 4;
   localparam int EVICT_W      = 5;
   localparam int OCC_W        = 5;

   // shared multiplier
   localparam int MUL_W        = (COORD_BITS > RADIUS_W) ? COORD_BITS : RADIUS_W;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int DIST_W       = PROD_W + 1;

   // register port
   localparam int CSR_ADDR_W   = 1;
   localparam int CSR_DATA_W   = (RADIUS_W > ABSENT_CFG_W) ? RADIUS_W : ABSENT_CFG_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_MATCH_RADIUS = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_ABSENT   = CSR_ADDR_W'(1);

   localparam logic [RADIUS_W-1:0]     RADIUS_RESET = RADIUS_W'(80);
   localparam logic [ABSENT_CFG_W-1:0] ABSENT_RESET = ABSENT_CFG_W'(8);
   localparam logic [ABSENT_W-1:0]     ABSENT_MAX   = '1;

   // item codes
   localparam logic FUNC_DETECT    = 1'b0;
   localparam logic FUNC_FRAME_END = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [COORD_BITS-1:0] x_pos;
      logic [COORD_BITS-1:0] y_pos;
   } req_type;

   typedef struct packed {
      logic               known;
      logic [SLOT_W-1:0]  slot;
      logic               full_res;
      logic [EVICT_W-1:0] evicted;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/centroid_track_table.sv -----
// Nearest-neighbour centroid tracker.
//
// Request channel (req_valid / req_stall / req_data): one beat is either a
// detection (func = detect, with x_pos / y_pos) or an end-of-frame marker.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one beat per
// request, in request order.
// Register port (csr_we / csr_index / csr_wdata): match_radius and
// max_absent, write only, to be written while the block is idle.
//
// A detection runs one shared multiplier: it squares the radius first,
// then for each stored entry squares dx, squares dy, and adds and
// compares; a decide step then updates the table and builds the
// response. An end-of-frame beat walks the table once, one entry a cycle.
// req_stall is high whenever an item is in progress. A finished response
// sits in an output register; a new request is taken while it waits, and
// only that item's completion waits for the response slot to drain.
// Reset empties the table and restores the register defaults; no sweep.
`default_nettype none

module centroid_track_table
   import ctt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire req_type               req_data,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      rsp_type               rsp_data,

   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LIMIT,
      S_SQX,
      S_SQY,
      S_CMP,
      S_DECIDE,
      S_AGE,
      S_DONE
   } state_type;

   // control and datapath registers
   state_type               state_ff,     state_in;
   logic [COUNT_W-1:0]      count_ff,     count_in;
   logic [COUNT_W-1:0]      scan_ff,      scan_in;
   logic [COUNT_W-1:0]      kept_ff,      kept_in;
   logic [DIST_W-1:0]       best_ff,      best_in;
   logic [IDX_W-1:0]        best_idx_ff,  best_idx_in;
   logic [PROD_W-1:0]       prod_ff,      prod_in;
   logic [PROD_W-1:0]       acc_ff,       acc_in;
   logic [PROD_W-1:0]       limit_ff,     limit_in;
   logic [COORD_BITS-1:0]   x_ff,         x_in;
   logic [COORD_BITS-1:0]   y_ff,         y_in;
   rsp_type                 res_ff,       res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff,  rsp_data_in;
   logic [RADIUS_W-1:0]     radius_ff;
   logic [ABSENT_CFG_W-1:0] max_absent_ff;

   // entry table
   logic [COORD_BITS-1:0]   entry_x_mem      [ENTRIES];
   logic [COORD_BITS-1:0]   entry_y_mem      [ENTRIES];
   logic [ABSENT_W-1:0]     entry_absent_mem [ENTRIES];
   logic [COORD_BITS-1:0]   rd_x_ff;
   logic [COORD_BITS-1:0]   rd_y_ff;
   logic [ABSENT_W-1:0]     rd_abs_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic [COORD_BITS-1:0]   mem_wx;
   logic [COORD_BITS-1:0]   mem_wy;
   logic [ABSENT_W-1:0]     mem_wabs;

   // shared multiplier
   logic [MUL_W-1:0]        mul_a;
   logic [MUL_W-1:0]        mul_b;
   logic [PROD_W-1:0]       mul_prod;

   logic [COORD_BITS-1:0]   dx;
   logic [COORD_BITS-1:0]   dy;
   logic [DIST_W-1:0]       dist_sum;
   logic [ABSENT_W-1:0]     abs_inc;
   logic [COUNT_W-1:0]      count_inc;
   logic [COUNT_W-1:0]      scan_inc;
   logic                    req_beat;
   logic                    hit;

   assign req_stall = (state_ff != S_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign dx        = (x_ff >= rd_x_ff) ? (x_ff - rd_x_ff) : (rd_x_ff - x_ff);
   assign dy        = (y_ff >= rd_y_ff) ? (y_ff - rd_y_ff) : (rd_y_ff - y_ff);
   assign dist_sum  = DIST_W'(acc_ff) + DIST_W'(prod_ff);
   assign abs_inc   = (rd_abs_ff == ABSENT_MAX) ? rd_abs_ff : rd_abs_ff + 1'b1;
   assign count_inc = count_ff + 1'b1;
   assign scan_inc  = scan_ff + 1'b1;
   assign hit       = (count_ff != '0) && (best_ff <= DIST_W'(limit_ff));

   // point the registered read at the entry the next cycle works on
   assign rd_addr   = (scan_in < COUNT_W'(ENTRIES)) ? IDX_W'(scan_in) : '0;

   always_comb begin
      unique case (state_ff)
         S_LIMIT: begin
            mul_a = MUL_W'(radius_ff);
            mul_b = MUL_W'(radius_ff);
         end
         S_SQX: begin
            mul_a = MUL_W'(dx);
            mul_b = MUL_W'(dx);
         end
         S_SQY: begin
            mul_a = MUL_W'(dy);
            mul_b = MUL_W'(dy);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_prod = mul_a * mul_b;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      kept_in      = kept_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      limit_in     = limit_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = best_idx_ff;
      mem_wx       = x_ff;
      mem_wy       = y_ff;
      mem_wabs     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               x_in    = req_data.x_pos;
               y_in    = req_data.y_pos;
               scan_in = '0;
               kept_in = '0;
               if (req_data.func == FUNC_FRAME_END) begin
                  state_in = S_AGE;
               end else begin
                  state_in = S_LIMIT;
               end
            end
         end

         S_LIMIT: begin
            limit_in = mul_prod;
            state_in = (count_ff == '0) ? S_DECIDE : S_SQX;
         end

         S_SQX: begin
            prod_in  = mul_prod;
            state_in = S_SQY;
         end

         S_SQY: begin
            acc_in   = prod_ff;
            prod_in  = mul_prod;
            state_in = S_CMP;
         end

         S_CMP: begin
            // strict less-than keeps the earliest entry on a tie
            if (scan_ff == '0 || dist_sum < best_ff) begin
               best_in     = dist_sum;
               best_idx_in = IDX_W'(scan_ff);
            end
            scan_in  = scan_inc;
            state_in = (scan_inc == count_ff) ? S_DECIDE : S_SQX;
         end

         S_DECIDE: begin
            res_in.evicted = '0;
            if (hit) begin
               mem_we             = 1'b1;
               mem_waddr          = best_idx_ff;
               res_in.known       = 1'b1;
               res_in.slot        = SLOT_W'(best_idx_ff);
               res_in.full_res    = 1'b0;
               res_in.occupancy   = OCC_W'(count_ff);
            end else if (count_ff < COUNT_W'(ENTRIES)) begin
               mem_we             = 1'b1;
               mem_waddr          = IDX_W'(count_ff);
               count_in           = count_inc;
               res_in.known       = 1'b0;
               res_in.slot        = SLOT_W'(count_ff);
               res_in.full_res    = 1'b0;
               res_in.occupancy   = OCC_W'(count_inc);
            end else begin
               // table full: drop the detection
               res_in.known       = 1'b0;
               res_in.slot        = '0;
               res_in.full_res    = 1'b1;
               res_in.occupancy   = OCC_W'(count_ff);
            end
            state_in = S_DONE;
         end

         S_AGE: begin
            if (scan_ff == count_ff) begin
               count_in         = kept_ff;
               res_in.known     = 1'b0;
               res_in.slot      = '0;
               res_in.full_res  = 1'b0;
               res_in.evicted   = EVICT_W'(count_ff - kept_ff);
               res_in.occupancy = OCC_W'(kept_ff);
               state_in         = S_DONE;
            end else begin
               scan_in = scan_inc;
               // keep the survivor, packed down behind the last kept entry
               if (abs_inc <= ABSENT_W'(max_absent_ff)) begin
                  mem_we    = 1'b1;
                  mem_waddr = IDX_W'(kept_ff);
                  mem_wx    = rd_x_ff;
                  mem_wy    = rd_y_ff;
                  mem_wabs  = abs_inc;
                  kept_in   = kept_ff + 1'b1;
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         radius_ff     <= RADIUS_RESET;
         max_absent_ff <= ABSENT_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MATCH_RADIUS: radius_ff     <= RADIUS_W'(csr_wdata);
               CSR_MAX_ABSENT:   max_absent_ff <= ABSENT_CFG_W'(csr_wdata);
            endcase
         end
      end
      scan_ff     <= scan_in;
      kept_ff     <= kept_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      limit_ff    <= limit_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_x_mem[mem_waddr]      <= mem_wx;
         entry_y_mem[mem_waddr]      <= mem_wy;
         entry_absent_mem[mem_waddr] <= mem_wabs;
      end
      rd_x_ff   <= entry_x_mem[rd_addr];
      rd_y_ff   <= entry_y_mem[rd_addr];
      rd_abs_ff <= entry_absent_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ctt_pkg::*;

   // run shape
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 172;
   localparam int HOLD_CYCLES     = 400;
   // worst item is a full-table detection; add the long receiver hold
   // and the longest sender gap, then take it several times
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 3 * ENTRIES + 12;
   localparam int MAX_REPORTS     = 40;
   localparam int COORD_MAX       = (1 << COORD_BITS) - 1;

   typedef enum {ROW_BEAT, ROW_WRITE} plan_kind_type;
   typedef enum {PACE_FREE, PACE_LIGHT, PACE_HEAVY, PACE_PERIODIC} pace_type;

   // one line of the directed plan: either a request beat or a register write
   typedef struct {
      plan_kind_type         kind;
      req_type               req;
      bit                    typed;
      rsp_type               want;
      logic [CSR_ADDR_W-1:0] reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
   } plan_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // tracker state as the testbench believes it to be
   logic [RADIUS_W-1:0]     radius_q     = RADIUS_RESET;
   logic [ABSENT_CFG_W-1:0] absent_limit = ABSENT_RESET;
   logic [COUNT_W-1:0]      track_count  = '0;
   logic [COORD_BITS-1:0]   track_x [ENTRIES];
   logic [COORD_BITS-1:0]   track_y [ENTRIES];
   logic [ABSENT_W-1:0]     track_miss [ENTRIES];

   // expected response beats, oldest first
   rsp_type pending_rsp [$];

   int fail_count  = 0;
   int idle_cycles = 0;
   int burst_left  = 0;
   int n_detect    = 0;
   int n_frame     = 0;
   int n_known     = 0;
   int n_new       = 0;
   int n_full      = 0;
   int n_evicted   = 0;
   int n_writes    = 0;
   int n_rsp       = 0;
   int peak_occ    = 0;
   bit hold_armed  = 1'b0;
   bit hold_done   = 1'b0;

   centroid_track_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Advance the tracker by one request and return the response it owes.
   // Detection: nearest entry by squared distance, earliest entry on a tie;
   // move it if inside the radius, else append, else drop on a full table.
   // Frame end: age every entry, drop the stale ones and close the gaps.
   function automatic rsp_type track_step(req_type r);
      rsp_type               res;
      longint unsigned       d2;
      longint unsigned       best;
      longint unsigned       limit;
      int                    best_i;
      int                    kept;
      int                    removed;
      int                    dx;
      int                    dy;
      bit                    found;
      logic [ABSENT_W-1:0]   miss;
      res     = '0;
      found   = 1'b0;
      best    = 0;
      best_i  = 0;
      kept    = 0;
      removed = 0;
      if (r.func == FUNC_DETECT) begin
         limit = longint'(radius_q) * longint'(radius_q);
         for (int i = 0; i < int'(track_count); i++) begin
            dx = int'(r.x_pos) - int'(track_x[i]);
            dy = int'(r.y_pos) - int'(track_y[i]);
            d2 = longint'(dx * dx) + longint'(dy * dy);
            // strict less-than keeps the earliest entry on a tie
            if (!found || d2 < best) begin
               best   = d2;
               best_i = i;
               found  = 1'b1;
            end
         end
         if (found && best <= limit) begin
            track_x[best_i]    = r.x_pos;
            track_y[best_i]    = r.y_pos;
            track_miss[best_i] = '0;
            res.known          = 1'b1;
            res.slot           = SLOT_W'(best_i);
         end else if (int'(track_count) < ENTRIES) begin
            track_x[track_count]    = r.x_pos;
            track_y[track_count]    = r.y_pos;
            track_miss[track_count] = '0;
            res.slot                = SLOT_W'(track_count);
            track_count             = track_count + 1'b1;
         end else begin
            res.full_res = 1'b1;
         end
      end else begin
         for (int i = 0; i < int'(track_count); i++) begin
            miss = track_miss[i];
            // the absence counter sticks at its ceiling
            if (miss != ABSENT_MAX)
               miss = miss + 1'b1;
            if (miss > ABSENT_W'(absent_limit)) begin
               removed++;
            end else begin
               track_x[kept]    = track_x[i];
               track_y[kept]    = track_y[i];
               track_miss[kept] = miss;
               kept++;
            end
         end
         track_count = COUNT_W'(kept);
         res.evicted = EVICT_W'(removed);
      end
      res.occupancy = OCC_W'(track_count);
      return res;
   endfunction

   // Draw one random request. Most are detections aimed at a live track,
   // a share of them right on the radius edge; the rest are frame ends,
   // corner positions and positions anywhere on the sensor.
   function automatic req_type random_item();
      req_type r;
      int      pick;
      int      i;
      int      reach;
      int      dx;
      int      dy;
      int      cx;
      int      cy;
      r.func  = FUNC_DETECT;
      r.x_pos = COORD_BITS'($urandom);
      r.y_pos = COORD_BITS'($urandom);
      pick    = $urandom_range(0, 99);
      if (pick < 14) begin
         r.func = FUNC_FRAME_END;
      end else if (pick < 66 && track_count != 0) begin
         i     = $urandom_range(0, int'(track_count) - 1);
         reach = int'(radius_q);
         if (pick < 26) begin
            // sit exactly on the radius or one pixel beyond it, along an axis
            dx = reach + int'($urandom_range(0, 1));
            dy = 0;
            if ($urandom_range(0, 1) == 1) begin
               dy = dx;
               dx = 0;
            end
            if ($urandom_range(0, 1) == 1)
               dx = -dx;
            if ($urandom_range(0, 1) == 1)
               dy = -dy;
         end else begin
            // mostly inside the radius, sometimes a little outside
            reach = reach + reach / 4 + 1;
            dx    = int'($urandom_range(0, 2 * reach)) - reach;
            dy    = int'($urandom_range(0, 2 * reach)) - reach;
         end
         cx      = int'(track_x[i]) + dx;
         cy      = int'(track_y[i]) + dy;
         cx      = (cx < 0) ? 0 : (cx > COORD_MAX) ? COORD_MAX : cx;
         cy      = (cy < 0) ? 0 : (cy > COORD_MAX) ? COORD_MAX : cy;
         r.x_pos = COORD_BITS'(cx);
         r.y_pos = COORD_BITS'(cy);
      end else if (pick < 72) begin
         r.x_pos = ($urandom_range(0, 1) == 1) ? COORD_BITS'(COORD_MAX) : '0;
         r.y_pos = ($urandom_range(0, 1) == 1) ? COORD_BITS'(COORD_MAX) : '0;
      end
      return r;
   endfunction

   function automatic plan_row_type beat_row(logic func, int x, int y);
      plan_row_type row;
      row.kind      = ROW_BEAT;
      row.req.func  = func;
      row.req.x_pos = COORD_BITS'(x);
      row.req.y_pos = COORD_BITS'(y);
      row.typed     = 1'b0;
      row.want      = '0;
      row.reg_idx   = '0;
      row.reg_val   = '0;
      return row;
   endfunction

   function automatic plan_row_type typed_row(plan_row_type row, int known, int slot,
                                               int full, int evicted, int occ);
      row.typed          = 1'b1;
      row.want.known     = 1'(known);
      row.want.slot      = SLOT_W'(slot);
      row.want.full_res  = 1'(full);
      row.want.evicted   = EVICT_W'(evicted);
      row.want.occupancy = OCC_W'(occ);
      return row;
   endfunction

   function automatic plan_row_type write_row(logic [CSR_ADDR_W-1:0] idx, int val);
      plan_row_type row;
      row         = beat_row(FUNC_DETECT, 0, 0);
      row.kind    = ROW_WRITE;
      row.reg_idx = idx;
      row.reg_val = CSR_DATA_W'(val);
      return row;
   endfunction

   task automatic report_mismatch(string field, int want_v, int got_v);
      if (fail_count < MAX_REPORTS)
         $display("[%0t] response beat %0d: %s expected %0d, got %0d",
                  $realtime, n_rsp, field, want_v, got_v);
      fail_count++;
   endtask

   // Offer one request beat in bursts with random gaps, hold it until taken,
   // then log what the tracker owes for it.
   task automatic send_beat(req_type r, bit typed, rsp_type want);
      rsp_type model_rsp;
      int      gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 :
               $urandom_range(1, ($urandom_range(0, 4) == 0) ? 70 : 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      model_rsp = track_step(r);
      // directed rows with a value typed in are held to that value
      pending_rsp = {pending_rsp, (typed ? want : model_rsp)};
      if (r.func == FUNC_DETECT) begin
         n_detect++;
         if (model_rsp.known)
            n_known++;
         else if (model_rsp.full_res)
            n_full++;
         else
            n_new++;
      end else begin
         n_frame++;
         n_evicted += int'(model_rsp.evicted);
      end
      if (int'(track_count) > peak_occ)
         peak_occ = int'(track_count);
   endtask

   // Drop valid, let every owed response drain, then write one register.
   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_MATCH_RADIUS)
         radius_q = RADIUS_W'(val);
      else
         absent_limit = ABSENT_CFG_W'(val);
      burst_left = 0;
      n_writes++;
   endtask

   // Response side: compare each accepted beat against the oldest owed one.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         n_rsp++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("beat with nothing owed, valid", 0, 1);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.known !== want.known)
               report_mismatch("known", int'(want.known), int'(rsp_data.known));
            if (rsp_data.slot !== want.slot)
               report_mismatch("slot", int'(want.slot), int'(rsp_data.slot));
            if (rsp_data.full_res !== want.full_res)
               report_mismatch("full_res", int'(want.full_res),
                               int'(rsp_data.full_res));
            if (rsp_data.evicted !== want.evicted)
               report_mismatch("evicted", int'(want.evicted), int'(rsp_data.evicted));
            if (rsp_data.occupancy !== want.occupancy)
               report_mismatch("occupancy", int'(want.occupancy),
                               int'(rsp_data.occupancy));
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles, %0d responses owed",
                  STALL_LIMIT, pending_rsp.size());
         $display("centroid_track_table regression: fail");
         $finish;
      end
   end

   // Receiver pacing: switch between free flow, light and heavy random
   // stalls and a fixed pattern; once, hold off for a long stretch so the
   // output register fills and the block backs up onto its input.
   initial begin : rsp_pacing
      pace_type mode;
      int       left;
      int       tick;
      mode = PACE_FREE;
      left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (left == 0) begin
               mode = pace_type'($urandom_range(0, 3));
               left = $urandom_range(40, 240);
            end
            left--;
            tick++;
            case (mode)
               PACE_FREE:  rsp_stall <= 1'b0;
               PACE_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               PACE_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 1);
               default:    rsp_stall <= ((tick % 8) < 3);
            endcase
         end
      end
   end

   initial begin : stimulus
      plan_row_type            plan [$];
      logic [RADIUS_W-1:0]     radius_plan [PHASES];
      logic [ABSENT_CFG_W-1:0] absent_plan [PHASES];

      // Directed plan, starting from the reset settings (radius 80, age 8).
      // Empty table: a frame end evicts nothing, the first detection lands
      // in slot 0.
      plan = {plan, typed_row(beat_row(FUNC_FRAME_END, 0, 0), 0, 0, 0, 0, 0)};
      plan = {plan, typed_row(beat_row(FUNC_DETECT, 0, 0), 0, 0, 0, 0, 1)};
      // the four sensor corners are far apart: each one appends
      plan = {plan, typed_row(beat_row(FUNC_DETECT, COORD_MAX, COORD_MAX), 0, 1, 0, 0, 2)};
      plan = {plan, typed_row(beat_row(FUNC_DETECT, COORD_MAX, 0), 0, 2, 0, 0, 3)};
      plan = {plan, typed_row(beat_row(FUNC_DETECT, 0, COORD_MAX), 0, 3, 0, 0, 4)};
      // a small step from the origin track: matched, moved in place
      plan = {plan, typed_row(beat_row(FUNC_DETECT, 10, 10), 1, 0, 0, 0, 4)};
      // a new track, then a point equidistant from two tracks: the earlier one must win
      plan = {plan, beat_row(FUNC_DETECT, 150, 10)};
      plan = {plan, beat_row(FUNC_DETECT, 80, 10)};
      // fill up to the last slot with well separated tracks
      for (int k = 0; k < 11; k++)
         plan = {plan, beat_row(FUNC_DETECT, 1000 + 200 * k, 2000)};
      // full table: an unmatched detection is dropped, a near one still matches
      plan = {plan, typed_row(beat_row(FUNC_DETECT, 3000, 3000), 0, 0, 1, 0, 16)};
      plan = {plan, beat_row(FUNC_DETECT, 4090, 4090)};
      // zero age limit: one frame end sweeps out the whole table
      plan = {plan, write_row(CSR_MAX_ABSENT, 0)};
      plan = {plan, typed_row(beat_row(FUNC_FRAME_END, 0, 0), 0, 0, 0, 16, 0)};
      // zero radius: only an exact hit counts as the same object
      plan = {plan, write_row(CSR_MATCH_RADIUS, 0)};
      plan = {plan, typed_row(beat_row(FUNC_DETECT, 5, 5), 0, 0, 0, 0, 1)};
      plan = {plan, typed_row(beat_row(FUNC_DETECT, 5, 6), 0, 1, 0, 0, 2)};
      plan = {plan, typed_row(beat_row(FUNC_DETECT, 5, 5), 1, 0, 0, 0, 2)};
      // widest radius and age limit
      plan = {plan, write_row(CSR_MATCH_RADIUS, COORD_MAX)};
      plan = {plan, write_row(CSR_MAX_ABSENT, 255)};
      plan = {plan, beat_row(FUNC_DETECT, COORD_MAX, COORD_MAX)};
      plan = {plan, typed_row(beat_row(FUNC_FRAME_END, 0, 0), 0, 0, 0, 0, 3)};

      // settings for the random phases, extremes included
      radius_plan = '{RADIUS_W'(80), RADIUS_W'(0), RADIUS_W'(4095), RADIUS_W'(1),
                      RADIUS_W'(24), RADIUS_W'(300), RADIUS_W'(80), RADIUS_W'(80)};
      absent_plan = '{ABSENT_CFG_W'(8), ABSENT_CFG_W'(0), ABSENT_CFG_W'(255),
                      ABSENT_CFG_W'(1), ABSENT_CFG_W'(3), ABSENT_CFG_W'(2),
                      ABSENT_CFG_W'(8), ABSENT_CFG_W'(8)};
      radius_plan[6] = RADIUS_W'($urandom);
      absent_plan[6] = ABSENT_CFG_W'($urandom_range(0, 20));

      // hold reset, then release it once for good
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         if (plan[k].kind == ROW_WRITE)
            write_reg(plan[k].reg_idx, plan[k].reg_val);
         else
            send_beat(plan[k].req, plan[k].typed, plan[k].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         write_reg(CSR_MATCH_RADIUS, CSR_DATA_W'(radius_plan[p]));
         write_reg(CSR_MAX_ABSENT, CSR_DATA_W'(absent_plan[p]));
         // start the long receiver hold while the sender keeps offering
         if (p == 3)
            hold_armed = 1'b1;
         repeat (ITEMS_PER_PHASE)
            send_beat(random_item(), 1'b0, '0);
      end

      // drain: every owed beat first, then a margin for strays
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("exercised %0d detections (%0d matched, %0d appended, %0d dropped when full)",
               n_detect, n_known, n_new, n_full);
      $display("and %0d frame ends evicting %0d tracks; %0d register writes, peak occupancy %0d",
               n_frame, n_evicted, n_writes, peak_occ);
      if (fail_count == 0)
         $display("centroid_track_table regression: pass");
      else
         $display("centroid_track_table regression: fail");
      $finish;
   end

endmodule
